/* rtl/core/bmscan_pkg.sv */
`default_nettype none

package bmscan_pkg;

   // Defaults for the top-level parameters
   localparam int MAGIC_BYTES_DEF = 6;
   localparam int OFFSET_BITS_DEF = 40;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Fixed field widths
   localparam int MAGIC_REG_W  = 48;
   localparam int LEVEL_W      = 8;
   localparam int OUT_OFFSET_W = 40;
   localparam int SHIFT_W      = 3;
   localparam int COUNTDOWN_W  = 4;

   // Config port
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 64;

   typedef logic [MAGIC_REG_W-1:0] magic_type;

   localparam magic_type BLOCK_MAGIC_RESET = 48'h3141_5926_5359;
   localparam magic_type END_MAGIC_RESET   = 48'h1772_4538_5090;

   // Register index, taken from paddr[3]
   localparam logic REG_BLOCK_MAGIC = 1'b0;
   localparam logic REG_END_MAGIC   = 1'b1;

   // boundary_kind codes
   localparam logic KIND_BLOCK = 1'b0;
   localparam logic KIND_END   = 1'b1;

   // Level byte is the fourth scanned byte of the stream
   localparam logic [COUNTDOWN_W-1:0] LEVEL_FIRST = 4'd4;

   // One scanned byte, classified by the front end
   typedef struct packed {
      logic [LEVEL_W-1:0]      cur;
      logic [SHIFT_W-1:0]      bits;
      logic                    hit_block;
      logic                    hit_end;
      logic [OUT_OFFSET_W-1:0] offset;
   } scan_entry_type;

endpackage

`default_nettype wire

/* rtl/core/bmscan_ifs.sv */
`default_nettype none

interface bmscan_req_if import bmscan_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface bmscan_rsp_if import bmscan_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    boundary_kind;
   logic [LEVEL_W-1:0]      stream_level;
   logic [OUT_OFFSET_W-1:0] byte_offset;
   logic [SHIFT_W-1:0]      bits_before;

   modport source (output valid, output boundary_kind, output stream_level,
                   output byte_offset, output bits_before, input ready);
   modport sink (input valid, input boundary_kind, input stream_level,
                 input byte_offset, input bits_before, output ready);
endinterface

`default_nettype wire

/* rtl/core/bmscan_front.sv */
`default_nettype none

module bmscan_front import bmscan_pkg::*; #(
   parameter int MAGIC_BYTES = MAGIC_BYTES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   bmscan_req_if.sink          req_ch,
   input  wire magic_type      block_magic,
   input  wire magic_type      end_magic,
   input  wire logic           queue_full,
   output logic                push,
   output scan_entry_type      push_entry
);

   localparam int MW     = 8 * MAGIC_BYTES;
   localparam int WIN_W  = 8 * (MAGIC_BYTES + 1);
   localparam int CW     = (MW > MAGIC_REG_W) ? MW : MAGIC_REG_W;
   localparam int FILL_W = $clog2(MAGIC_BYTES + 1);

   logic [WIN_W-1:0]       window_ff, window_in;
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;

   logic                   accept;
   logic                   scan;
   logic [OFFSET_BITS-1:0] pos;
   logic [CW-1:0]          bmx, emx;
   logic [15:0]            bhl, ehl;
   logic [7:0]             cur;
   logic [7:0]             hit_mask;
   logic [SHIFT_W-1:0]     bsel;
   logic                   any_hit;
   logic [MW-1:0]          v;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   always_comb begin
      window_in = {window_ff[WIN_W-9:0], req_ch.data_byte};
      seen_in   = seen_ff + OFFSET_BITS'(1);
      fill_in   = (fill_ff < FILL_W'(MAGIC_BYTES)) ? fill_ff + FILL_W'(1) : fill_ff;
      scan      = (fill_in == FILL_W'(MAGIC_BYTES));
      pos       = seen_in - OFFSET_BITS'(MAGIC_BYTES);
   end

   // Candidate shift: the largest b whose shifted head byte fits the scanned byte
   always_comb begin
      logic [15:0] bsh, esh;
      bmx = CW'(block_magic);
      emx = CW'(end_magic);
      bhl = {bmx[MW-1 -: 8], bmx[MW-9 -: 8]};
      ehl = {emx[MW-1 -: 8], emx[MW-9 -: 8]};
      cur = window_in[MW-1 -: 8];
      bsel = '0;
      for (int k = 0; k < 8; k++) begin
         bsh = bhl << SHIFT_W'(k);
         esh = ehl << SHIFT_W'(k);
         hit_mask[k] = (bsh[15:8] == cur) || (esh[15:8] == cur);
      end
      for (int k = 0; k < 8; k++) begin
         if (hit_mask[k]) begin
            bsel = SHIFT_W'(k);
         end
      end
      any_hit = |hit_mask;
      v = MW'(window_in >> bsel);
   end

   always_comb begin
      push                 = accept && scan;
      push_entry.cur       = cur;
      push_entry.bits      = bsel;
      push_entry.hit_block = any_hit && (CW'(v) == bmx);
      push_entry.hit_end   = any_hit && (CW'(v) == emx);
      push_entry.offset    = OUT_OFFSET_W'(pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
         fill_ff   <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bmscan_fifo.sv */
`default_nettype none

module bmscan_fifo import bmscan_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire scan_entry_type push_entry,
   input  wire logic           pop,
   output scan_entry_type      head,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   scan_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a write");
`endif

endmodule

`default_nettype wire

/* rtl/core/bmscan_back.sv */
`default_nettype none

module bmscan_back import bmscan_pkg::*; #(
   parameter int MAGIC_BYTES = MAGIC_BYTES_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire scan_entry_type head,
   input  wire logic           empty,
   output logic                pop,
   bmscan_rsp_if.source        rsp_ch
);

   // Level byte follows an end-of-stream magic, its CRC and the stream header
   localparam logic [COUNTDOWN_W-1:0] LEVEL_AFTER_END = COUNTDOWN_W'(MAGIC_BYTES + 7);

   logic [COUNTDOWN_W-1:0]  countdown_ff, countdown_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic                    valid_ff, valid_in;
   logic                    kind_ff, kind_in;
   logic [LEVEL_W-1:0]      olevel_ff, olevel_in;
   logic [OUT_OFFSET_W-1:0] offset_ff, offset_in;
   logic [SHIFT_W-1:0]      bits_ff, bits_in;
   logic                    hit;

   assign pop = !empty && (!valid_ff || rsp_ch.ready);
   assign hit = head.hit_block || head.hit_end;

   always_comb begin
      countdown_in = countdown_ff;
      level_in     = level_ff;
      valid_in     = valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      olevel_in    = olevel_ff;
      offset_in    = offset_ff;
      bits_in      = bits_ff;
      if (pop) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - COUNTDOWN_W'(1);
            if (countdown_ff == COUNTDOWN_W'(1)) begin
               level_in = head.cur;
            end
         end
         if (hit) begin
            valid_in  = 1'b1;
            kind_in   = head.hit_block ? KIND_BLOCK : KIND_END;
            olevel_in = level_in;
            offset_in = head.offset;
            bits_in   = head.bits;
            if (!head.hit_block) begin
               countdown_in = LEVEL_AFTER_END;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= LEVEL_FIRST;
         level_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         countdown_ff <= countdown_in;
         level_ff     <= level_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      olevel_ff <= olevel_in;
      offset_ff <= offset_in;
      bits_ff   <= bits_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.boundary_kind = kind_ff;
   assign rsp_ch.stream_level  = olevel_ff;
   assign rsp_ch.byte_offset   = offset_ff;
   assign rsp_ch.bits_before   = bits_ff;

`ifndef SYNTHESIS
   a_end_reload: assert property (@(posedge clock) disable iff (reset)
      (pop && head.hit_end && !head.hit_block) |=> countdown_ff == LEVEL_AFTER_END)
      else $error("end-of-stream match did not rearm level countdown");
   a_level_load: assert property (@(posedge clock) disable iff (reset)
      (pop && countdown_ff == COUNTDOWN_W'(1)) |=> level_ff == $past(head.cur))
      else $error("level byte not captured");
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ch.ready) |-> !pop)
      else $error("queue popped over a pending result");
`endif

endmodule

`default_nettype wire

/* rtl/core/bzip2_block_magic_scanner.sv */
// Channel   Direction  Transaction payload
// req_ch    in         data_byte: next byte of the compressed stream
// rsp_ch    out        boundary_kind, stream_level, byte_offset, bits_before
// apb csr   in/out     reg 0 block_magic @0x0, reg 1 stream_end_magic @0x8
//
// One byte per cycle sustained while the queue is not full. Front end shifts the byte
// window and runs the eight shifted head compares plus both 48-bit magic compares
// in the accept cycle. A result is registered in the cycle after its scanned byte
// leaves the queue; a match passes through the queue slot, then the result register.
// Synchronous active-high reset; magics return to their defaults.
// The queue absorbs rsp stalls; req_ch.ready drops only when it is full.
`default_nettype none

module bzip2_block_magic_scanner import bmscan_pkg::*; #(
   parameter int MAGIC_BYTES = MAGIC_BYTES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   bmscan_req_if.sink              req_ch,
   bmscan_rsp_if.source            rsp_ch,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   magic_type      block_magic_ff, block_magic_in;
   magic_type      end_magic_ff, end_magic_in;
   logic           csr_write;
   logic           push, pop, full, empty;
   scan_entry_type push_entry, head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      block_magic_in = block_magic_ff;
      end_magic_in   = end_magic_ff;
      if (csr_write) begin
         case (paddr[3])
            REG_BLOCK_MAGIC: block_magic_in = pwdata[MAGIC_REG_W-1:0];
            REG_END_MAGIC:   end_magic_in   = pwdata[MAGIC_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3])
         REG_BLOCK_MAGIC: prdata = PDATA_W'(block_magic_ff);
         REG_END_MAGIC:   prdata = PDATA_W'(end_magic_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_magic_ff <= BLOCK_MAGIC_RESET;
         end_magic_ff   <= END_MAGIC_RESET;
      end else begin
         block_magic_ff <= block_magic_in;
         end_magic_ff   <= end_magic_in;
      end
   end

   bmscan_front #(
      .MAGIC_BYTES (MAGIC_BYTES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .block_magic (block_magic_ff),
      .end_magic   (end_magic_ff),
      .queue_full  (full),
      .push        (push),
      .push_entry  (push_entry)
   );

   bmscan_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   bmscan_back #(
      .MAGIC_BYTES (MAGIC_BYTES)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb import bmscan_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_W = 8 * (MAGIC_BYTES_DEF + 1);
   localparam logic [COUNTDOWN_W-1:0] LEVEL_AFTER_END = COUNTDOWN_W'(MAGIC_BYTES_DEF + 7);
   localparam int DRAIN_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                    kind;
      logic [LEVEL_W-1:0]      level;
      logic [OUT_OFFSET_W-1:0] offset;
      logic [SHIFT_W-1:0]      bits;
   } boundary_type;

   class boundary_scoreboard;
      magic_type               block_pattern;
      magic_type               end_pattern;
      logic [WINDOW_W-1:0]     window;
      logic [OFFSET_BITS_DEF-1:0] byte_count;
      logic [LEVEL_W-1:0]      level;
      logic [COUNTDOWN_W-1:0]  level_wait;
      int unsigned             fill;
      boundary_type            expected_boundaries[$];
      int unsigned             mismatches;

      function void clear();
         block_pattern = BLOCK_MAGIC_RESET;
         end_pattern = END_MAGIC_RESET;
         window = '0;
         byte_count = '0;
         level = '0;
         level_wait = LEVEL_FIRST;
         fill = 0;
         expected_boundaries.delete();
         mismatches = 0;
      endfunction

      function void set_pattern(logic reg_index, magic_type pattern);
         if (reg_index == REG_BLOCK_MAGIC) begin
            block_pattern = pattern;
         end else begin
            end_pattern = pattern;
         end
      endfunction

      // first magic byte as it looks when the magic is shifted left by b bits
      function logic [7:0] head_at(magic_type pattern, int b);
         logic [15:0] top;
         top = pattern[MAGIC_REG_W-1 -: 16] << b;
         return top[15:8];
      endfunction

      function void note_byte(logic [7:0] data);
         logic [7:0]          cur;
         logic [WINDOW_W-1:0] shifted;
         magic_type           candidate;
         int                  shift;
         boundary_type        want;
         window = {window[WINDOW_W-9:0], data};
         byte_count = byte_count + 1'b1;
         if (fill < MAGIC_BYTES_DEF) fill++;
         if (fill < MAGIC_BYTES_DEF) return;
         cur = window[8*MAGIC_BYTES_DEF-1 -: 8];
         if (level_wait != 0) begin
            level_wait = level_wait - 1'b1;
            if (level_wait == 0) level = cur;
         end
         // only the largest fitting shift gets a full compare
         shift = -1;
         for (int k = 7; k >= 0 && shift < 0; k--) begin
            if (head_at(block_pattern, k) == cur || head_at(end_pattern, k) == cur) shift = k;
         end
         if (shift < 0) return;
         shifted = window >> shift;
         candidate = shifted[MAGIC_REG_W-1:0];
         if (candidate != block_pattern && candidate != end_pattern) return;
         want.kind = (candidate == block_pattern) ? KIND_BLOCK : KIND_END;
         want.level = level;
         want.offset = OUT_OFFSET_W'(byte_count - MAGIC_BYTES_DEF);
         want.bits = SHIFT_W'(shift);
         if (want.kind == KIND_END) level_wait = LEVEL_AFTER_END;
         expected_boundaries = {expected_boundaries, want};
      endfunction

      function void check_boundary(boundary_type got);
         boundary_type want;
         if (expected_boundaries.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: unexpected boundary kind=%0d level=%02h offset=%0d bits=%0d",
                        got.kind, got.level, got.offset, got.bits);
            return;
         end
         want = expected_boundaries.pop_front();
         if (got.kind !== want.kind || got.level !== want.level ||
             got.offset !== want.offset || got.bits !== want.bits) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: boundary mismatch expected %s, got %s",
                        $sformatf("kind=%0d level=%02h offset=%0d bits=%0d",
                                  want.kind, want.level, want.offset, want.bits),
                        $sformatf("kind=%0d level=%02h offset=%0d bits=%0d",
                                  got.kind, got.level, got.offset, got.bits));
         end
      endfunction

      function bit drained();
         return expected_boundaries.size() == 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   wire logic [PDATA_W-1:0] prdata;
   wire logic pready;

   bmscan_req_if req_ch ();
   bmscan_rsp_if rsp_ch ();

   boundary_scoreboard sb;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;
   bit bit_q[$];
   logic [7:0] byte_q[$];

   bzip2_block_magic_scanner DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // result side: random backpressure and checking
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_boundary({rsp_ch.boundary_kind, rsp_ch.stream_level,
                            rsp_ch.byte_offset, rsp_ch.bits_before});
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // bit-level stream builder, MSB first, so magics land at any alignment
   function automatic void push_bits(logic [63:0] value, int count);
      logic [7:0] packed_byte;
      for (int i = count - 1; i >= 0; i--) bit_q = {bit_q, bit'(value[i])};
      while (bit_q.size() >= 8) begin
         for (int j = 7; j >= 0; j--) packed_byte[j] = bit_q.pop_front();
         byte_q = {byte_q, packed_byte};
      end
   endfunction

   function automatic void pad_to_byte();
      if (bit_q.size() != 0) push_bits(64'd0, 8 - bit_q.size());
   endfunction

   function automatic magic_type maybe_corrupt(magic_type pattern);
      if ($urandom_range(9) == 0) return pattern ^ (48'd1 << $urandom_range(47));
      return pattern;
   endfunction

   function automatic void push_random_bits(int count);
      int chunk;
      while (count > 0) begin
         chunk = (count > 32) ? 32 : count;
         push_bits(64'($urandom), chunk);
         count -= chunk;
      end
   endfunction

   // mostly well-formed streams; some noise and streams cut short
   function automatic void build_streams(int target);
      int pick;
      while (byte_q.size() < target) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            push_random_bits(8 * $urandom_range(1, 24));
         end else begin
            push_bits(64'h42_5A68, 24);
            if ($urandom_range(7) == 0) push_bits(64'($urandom), 8);
            else push_bits(64'h30 + $urandom_range(1, 9), 8);
            repeat ($urandom_range(1, 3)) begin
               push_bits(maybe_corrupt(sb.block_pattern), MAGIC_REG_W);
               push_random_bits($urandom_range(0, 160));
            end
            if (pick != 1) begin
               push_bits(maybe_corrupt(sb.end_pattern), MAGIC_REG_W);
               push_random_bits(32);
            end
            pad_to_byte();
         end
      end
      pad_to_byte();
   endfunction

   task automatic send_bytes();
      int pause_at;
      pause_at = $urandom_range(0, byte_q.size() - 1);
      foreach (byte_q[i]) begin
         if (i == pause_at) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (!sb.drained()) @(posedge clock);
         end
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.data_byte <= byte_q[i];
         do @(posedge clock); while (!req_ch.ready);
         sb.note_byte(byte_q[i]);
      end
      req_ch.valid <= 1'b0;
      byte_q.delete();
   endtask

   task automatic wait_idle();
      while (!sb.drained()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_index, magic_type pattern);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 3'b000};
      pwdata <= {16'($urandom), pattern};  // upper bits are don't-care
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_pattern(reg_index, pattern);
      @(posedge clock);
   endtask

   task automatic run_phase(int target);
      build_streams(target);
      send_bytes();
      wait_idle();
   endtask

   initial begin
      magic_type shared;
      sb = new;
      sb.clear();
      send_idle_pct = 17;
      recv_idle_pct = 85;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end magic at offset 0 with its top three bits in the zero bytes before the stream
      push_bits(64'(END_MAGIC_RESET), 45);
      push_bits(64'b101, 3);
      push_bits(64'h425A_6839, 32);
      push_bits(64'(BLOCK_MAGIC_RESET), MAGIC_REG_W);
      push_bits(64'h00FF, 16);
      push_bits(64'b11111, 5);
      push_bits(64'(END_MAGIC_RESET), MAGIC_REG_W);
      push_bits(64'd0, 3);
      send_bytes();
      wait_idle();

      run_phase(400);

      send_idle_pct = 85;
      recv_idle_pct = 17;
      csr_write(REG_BLOCK_MAGIC, '1);
      csr_write(REG_END_MAGIC, '0);
      run_phase(250);
      csr_write(REG_BLOCK_MAGIC, {16'($urandom), 32'($urandom)});
      csr_write(REG_END_MAGIC, {16'($urandom), 32'($urandom)});
      run_phase(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // identical patterns: every match reports as a block start
      shared = {16'($urandom), 32'($urandom)};
      csr_write(REG_BLOCK_MAGIC, shared);
      csr_write(REG_END_MAGIC, shared);
      run_phase(200);
      csr_write(REG_BLOCK_MAGIC, '0);
      csr_write(REG_END_MAGIC, '1);
      run_phase(300);

      if (!sb.drained())
         $display("ERROR: %0d expected boundaries never arrived",
                  sb.expected_boundaries.size());
      if (sb.mismatches == 0 && sb.drained()) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
